// ===== src/fraction_arith_gcd_reduce_unit_macros.svh =====
// Assertion macros for the fraction reduction unit.
// Taken in by the top level; expects clk_i and rst_ni in scope.
`ifndef FRACTION_ARITH_GCD_REDUCE_UNIT_MACROS_SVH
`define FRACTION_ARITH_GCD_REDUCE_UNIT_MACROS_SVH

// Same-cycle implication
`define FAGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FAGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fagr_pkg.sv =====
// Shared constants and helpers for the fraction reduction unit.
// No dependencies.
package fagr_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 32;

  // Operation codes
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // Width of the raw cross-product values, capped at 64 bits
  function automatic int unsigned raw_width(input int unsigned w);
    int unsigned r;
    r = 2 * w + 1;
    return (r > 64) ? 64 : r;
  endfunction

endpackage

// ===== src/fraction_arith_gcd_reduce_unit.sv =====
// Fraction add/sub/mul/div with GCD reduction. From acceptance to strobe the unit runs
// the multiply and check states, then binary GCD steps until x reaches zero, then two
// divisions by the GCD on the shared RW-bit divider (RW = 33), numerator first.
// One request at a time; busy is high until the strobe, when the next may be taken.
// A zero denominator strobes from the check state, skipping GCD and division. Receiver cannot stall; async reset.
`include "fraction_arith_gcd_reduce_unit_macros.svh"
module fraction_arith_gcd_reduce_unit
  import fagr_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic                            res_valid_o,
  output logic signed [NUM_W-1:0]         res_num_o,
  output logic signed [DEN_W-1:0]         res_den_o,
  output logic                            zero_den_error_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned RW = raw_width(OPERAND_WIDTH);
  localparam int unsigned KW = $clog2(RW + 1);

  // Sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL1    = 4'd1;
  localparam logic [3:0] S_MUL2    = 4'd2;
  localparam logic [3:0] S_MUL3    = 4'd3;
  localparam logic [3:0] S_CHK     = 4'd4;
  localparam logic [3:0] S_GCD     = 4'd5;
  localparam logic [3:0] S_DIVN_GO = 4'd6;
  localparam logic [3:0] S_DIVN_W  = 4'd7;
  localparam logic [3:0] S_DIVD_GO = 4'd8;
  localparam logic [3:0] S_DIVD_W  = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [1:0]            act_q;
  logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q;
  logic signed [2*W-1:0] prod_q, prod_d;
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [RW-1:0]  p1_q, rn_q, prod_ext;
  logic [RW-1:0]         magn_q, magd_q, x_q, y_q, g_q, qn_q;
  logic                  negn_q, negd_q;
  logic [KW-1:0]         k_q;
  logic                  valid_q;
  logic signed [NUM_W-1:0] num_q;
  logic signed [DEN_W-1:0] den_q;
  logic                  err_q;
  logic                  div_start, div_done;
  logic [RW-1:0]         div_n, div_q;
  logic signed [RW-1:0]  sq_n, sq_d;

  // Shared multiplier operand selection
  always_comb begin
    unique case (state_q)
      S_MUL1:  begin mul_a = an_q; mul_b = (act_q == ACT_MUL) ? bn_q : bd_q; end
      S_MUL2:  begin mul_a = ad_q; mul_b = bn_q; end
      default: begin mul_a = ad_q; mul_b = (act_q == ACT_DIV) ? bn_q : bd_q; end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = RW'(prod_q);

  // Divider is shared between numerator and denominator
  assign div_start = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO);
  assign div_n     = (state_q == S_DIVN_GO) ? magn_q : magd_q;

  fagr_divider #(.W(RW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (g_q),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  // Signed quotients
  assign sq_n = negn_q ? -$signed(qn_q) : $signed(qn_q);
  assign sq_d = negd_q ? -$signed(div_q) : $signed(div_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (start) state_d = S_MUL1;
      S_MUL1:    state_d = S_MUL2;
      S_MUL2:    state_d = S_MUL3;
      S_MUL3:    state_d = S_CHK;
      S_CHK:     state_d = (prod_ext == '0) ? S_IDLE : S_GCD;
      S_GCD:     if (x_q == '0) state_d = S_DIVN_GO;
      S_DIVN_GO: state_d = S_DIVN_W;
      S_DIVN_W:  if (div_done) state_d = S_DIVD_GO;
      S_DIVD_GO: state_d = S_DIVD_W;
      S_DIVD_W:  if (div_done) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= ((state_q == S_CHK) && (prod_ext == '0)) ||
                 ((state_q == S_DIVD_W) && div_done);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == S_IDLE && start) begin
      act_q <= action_i;
      an_q  <= a_num_i;
      ad_q  <= a_den_i;
      bn_q  <= b_num_i;
      bd_q  <= b_den_i;
    end
    if (state_q == S_MUL2) p1_q <= prod_ext;
    if (state_q == S_MUL3) begin
      unique case (act_q)
        ACT_ADD: rn_q <= p1_q + prod_ext;
        ACT_SUB: rn_q <= p1_q - prod_ext;
        default: rn_q <= p1_q;
      endcase
    end
    if (state_q == S_CHK) begin
      negn_q <= rn_q[RW-1];
      negd_q <= prod_ext[RW-1];
      magn_q <= rn_q[RW-1] ? RW'(-rn_q) : RW'(rn_q);
      magd_q <= prod_ext[RW-1] ? RW'(-prod_ext) : RW'(prod_ext);
      x_q    <= rn_q[RW-1] ? RW'(-rn_q) : RW'(rn_q);
      y_q    <= prod_ext[RW-1] ? RW'(-prod_ext) : RW'(prod_ext);
      k_q    <= '0;
      if (prod_ext == '0) begin
        num_q <= '0;
        den_q <= '0;
        err_q <= 1'b1;
      end
    end
    // Binary GCD step; y never reaches zero
    if (state_q == S_GCD) begin
      if (x_q == '0) begin
        g_q <= y_q << k_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
    if (state_q == S_DIVN_W && div_done) qn_q <= div_q;
    if (state_q == S_DIVD_W && div_done) begin
      num_q <= NUM_W'(sq_n);
      den_q <= DEN_W'(sq_d);
      err_q <= 1'b0;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign res_valid_o      = valid_q;
  assign res_num_o        = num_q;
  assign res_den_o        = den_q;
  assign zero_den_error_o = err_q;

  // Checks
  `FAGR_ASSERT_NOW(a_err_zero, res_valid_o && zero_den_error_o, (res_num_o == '0) && (res_den_o == '0), "error result not zero")
  `FAGR_ASSERT_NOW(a_den_nz, res_valid_o && !zero_den_error_o, res_den_o != '0, "zero denominator without error")
  `FAGR_ASSERT_NEXT(a_busy_after, start && !busy, busy, "request accepted but not busy")
  `FAGR_ASSERT_NEXT(a_one_strobe, res_valid_o, !res_valid_o, "result strobe held")

endmodule

// ===== src/fagr_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the fraction reduction unit.
module fagr_divider #(
  parameter int unsigned W = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          active_q, active_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  div_q, div_d;
  logic [W:0]    rem_sh;
  logic          fits;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_q[W-1:0], quo_q[W-1]};
    fits    = (rem_sh >= {1'b0, div_q});
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    div_d    = div_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = CW'(W - 1);
      rem_d    = '0;
      quo_d    = dividend_i;
      div_d    = divisor_i;
    end else if (active_q) begin
      rem_d = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sim/fraction_arith_gcd_reduce_unit_tb.sv =====
// Testbench for the fraction reduction unit: directed table then random requests,
// each result checked against a behavioural predictor. Depends on fagr_pkg and the unit.
module fraction_arith_gcd_reduce_unit_tb;
  import fagr_pkg::*;

  localparam int unsigned OW = OPERAND_WIDTH_DEF;
  localparam int unsigned N_RANDOM = 1630;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    err;
  } frac_res_t;

  typedef struct {
    logic [1:0]           act;
    logic signed [OW-1:0] an, ad, bn, bd;
    logic                 has_exp;
    frac_res_t            exp_res;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              action_i = ACT_ADD;
  logic signed [OW-1:0]    a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic                    res_valid_o;
  logic signed [NUM_W-1:0] res_num_o;
  logic signed [DEN_W-1:0] res_den_o;
  logic                    zero_den_error_o;

  frac_res_t reduced_q[$];
  int        n_fail = 0;
  int        n_results = 0;
  int        n_errors_seen = 0;
  longint    cycle_cnt = 0;
  int        idle_pct = 0;

  fraction_arith_gcd_reduce_unit #(.OPERAND_WIDTH(OW)) dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predict the reduced fraction for one request
  function automatic frac_res_t reduce_fraction(logic [1:0] act, logic signed [OW-1:0] an,
                                                logic signed [OW-1:0] ad,
                                                logic signed [OW-1:0] bn,
                                                logic signed [OW-1:0] bd);
    longint    rn, rd, x, y, t;
    frac_res_t r;
    case (act)
      ACT_ADD: begin
        rn = longint'(an) * bd + longint'(ad) * bn;
        rd = longint'(ad) * bd;
      end
      ACT_SUB: begin
        rn = longint'(an) * bd - longint'(ad) * bn;
        rd = longint'(ad) * bd;
      end
      ACT_MUL: begin
        rn = longint'(an) * bn;
        rd = longint'(ad) * bd;
      end
      default: begin
        rn = longint'(an) * bd;
        rd = longint'(ad) * bn;
      end
    endcase
    if (rd == 0) begin
      r.num = '0;
      r.den = '0;
      r.err = 1'b1;
      return r;
    end
    x = (rn < 0) ? -rn : rn;
    y = (rd < 0) ? -rd : rd;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 1;
    rn = rn / x;
    rd = rd / x;
    r.num = rn[NUM_W-1:0];
    r.den = rd[DEN_W-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  // Issue one request once the unit is free; busy is stable at the falling edge,
  // so start raised there is taken at the next rising edge
  task automatic send_request(logic [1:0] act, logic signed [OW-1:0] an,
                              logic signed [OW-1:0] ad, logic signed [OW-1:0] bn,
                              logic signed [OW-1:0] bd);
    while (busy) @(negedge clk_i);
    while ($urandom_range(99, 0) < idle_pct) @(negedge clk_i);
    action_i <= act;
    a_num_i  <= an;
    a_den_i  <= ad;
    b_num_i  <= bn;
    b_den_i  <= bd;
    start    <= 1'b1;
    reduced_q.push_back(reduce_fraction(act, an, ad, bn, bd));
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    frac_res_t want;
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (zero_den_error_o) n_errors_seen++;
      if (reduced_q.size() == 0) begin
        $error("result with no request pending");
        n_fail++;
      end else begin
        want = reduced_q.pop_front();
        if (res_num_o !== want.num) begin
          $error("res_num: expected %0d, got %0d", want.num, res_num_o);
          n_fail++;
        end
        if (res_den_o !== want.den) begin
          $error("res_den: expected %0d, got %0d", want.den, res_den_o);
          n_fail++;
        end
        if (zero_den_error_o !== want.err) begin
          $error("zero_den_error: expected %0b, got %0b", want.err, zero_den_error_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[fraction_arith_gcd_reduce_unit] ERROR");
      $finish;
    end
  end

  // Random operand: mostly small, sometimes zero, extreme or full range
  function automatic logic signed [OW-1:0] rand_operand();
    case ($urandom_range(5, 0))
      0: return OW'($urandom);
      1: return $urandom_range(1, 0) ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      2: return '0;
      default: return OW'($signed($urandom_range(200, 0)) - 100);
    endcase
  endfunction

  localparam logic signed [OW-1:0] MAXV = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] MINV = {1'b1, {(OW-1){1'b0}}};

  dir_row_t dir_tbl[] = '{
    '{ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd5, 32'sd6, 1'b0}},
    '{ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, '{33'sd0, 32'sd1, 1'b0}},
    '{ACT_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4, 1'b1, '{33'sd1, 32'sd2, 1'b0}},
    '{ACT_DIV, 16'sd1, 16'sd2, 16'sd1, 16'sd4, 1'b1, '{33'sd2, 32'sd1, 1'b0}},
    '{ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 1'b1, '{33'sd0, 32'sd0, 1'b1}},
    '{ACT_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd3, 1'b1, '{33'sd0, 32'sd0, 1'b1}},
    '{ACT_MUL, 16'sd0, 16'sd5, 16'sd3, -16'sd7, 1'b1, '{33'sd0, -32'sd1, 1'b0}},
    '{ACT_MUL, MINV, 16'sd1, MINV, 16'sd1, 1'b1, '{33'sd1073741824, 32'sd1, 1'b0}},
    '{ACT_ADD, MAXV, MINV, MAXV, MINV, 1'b0, '0},
    '{ACT_SUB, MINV, MAXV, MAXV, MINV, 1'b0, '0},
    '{ACT_ADD, MINV, 16'sd1, MINV, 16'sd1, 1'b0, '0},
    '{ACT_DIV, MINV, MINV, MINV, MINV, 1'b0, '0},
    '{ACT_DIV, MAXV, -16'sd1, MINV, 16'sd3, 1'b0, '0},
    '{ACT_SUB, -16'sd3, 16'sd6, 16'sd5, -16'sd10, 1'b0, '0},
    '{ACT_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
    '{ACT_ADD, 16'sd0, -16'sd4, 16'sd0, 16'sd8, 1'b0, '0},
    '{ACT_DIV, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b0, '0},
    '{ACT_MUL, MAXV, MAXV, MAXV, MAXV, 1'b0, '0},
    '{ACT_SUB, 16'sd12345, 16'sd678, -16'sd999, 16'sd0, 1'b0, '0},
    '{ACT_ADD, 16'sd1, 16'sd2, 16'sd1, -16'sd2, 1'b0, '0}
  };

  // Stimulus
  initial begin
    int phase;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed table; typed expectations cross-check the predictor
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].has_exp &&
          reduce_fraction(dir_tbl[i].act, dir_tbl[i].an, dir_tbl[i].ad, dir_tbl[i].bn,
                          dir_tbl[i].bd) !== dir_tbl[i].exp_res) begin
        $error("directed row %0d: table and predictor disagree", i);
        n_fail++;
      end
      send_request(dir_tbl[i].act, dir_tbl[i].an, dir_tbl[i].ad, dir_tbl[i].bn,
                   dir_tbl[i].bd);
    end
    // Random requests in idling phases
    for (int k = 0; k < N_RANDOM; k++) begin
      phase = (k * 4) / N_RANDOM;
      idle_pct = (phase == 1) ? 84 : (phase == 3) ? 7 : 0;
      send_request(2'($urandom), rand_operand(), rand_operand(), rand_operand(),
                   rand_operand());
    end
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d requests in four idling phases; %0d results, %0d zero-denominator.",
             dir_tbl.size() + N_RANDOM, n_results, n_errors_seen);
    if (n_fail == 0) begin
      $display("[fraction_arith_gcd_reduce_unit] OK");
    end else begin
      $display("[fraction_arith_gcd_reduce_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/fagr_pkg.sv
src/fagr_divider.sv
src/fraction_arith_gcd_reduce_unit.sv
sim/fraction_arith_gcd_reduce_unit_tb.sv
